// File: rtl/core/aescbc_pkg.sv
// ----------------------------------------------------------------------------
// aescbc_pkg
// Shared codes, S-box tables and AES round functions for the CBC stream block.
// ----------------------------------------------------------------------------
`default_nettype none

package aescbc_pkg;

    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_DATA   = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_ENC  = 2'd1;
    localparam logic [1:0] MODE_DEC  = 2'd2;
    localparam logic [1:0] MODE_ERR  = 2'd3;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_LEN = 2'd1;
    localparam logic [1:0] ST_PAD = 2'd2;

    localparam logic [2:0] REG_DIR   = 3'd0;
    localparam logic [2:0] REG_KSIZE = 3'd1;
    localparam logic [2:0] REG_KEY0  = 3'd2;
    localparam logic [2:0] REG_KEY1  = 3'd3;
    localparam logic [2:0] REG_KEY2  = 3'd4;
    localparam logic [2:0] REG_KEY3  = 3'd5;
    localparam logic [2:0] REG_IVHI  = 3'd6;
    localparam logic [2:0] REG_IVLO  = 3'd7;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [0:255] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte 0 is the most significant byte, byte i = 4*column + row
    function automatic logic [127:0] enc_round(input logic [127:0] s,
                                               input logic [127:0] k,
                                               input logic         last);
        logic [7:0]   a [16];
        logic [7:0]   t [16];
        logic [7:0]   x;
        logic [7:0]   a0;
        logic [127:0] r;
        for (int i = 0; i < 16; i++)
        begin
            a[i] = SBOX[s[127-8*i -: 8]];
        end
        for (int i = 0; i < 16; i++)
        begin
            t[i] = a[(i & 3) + 4 * (((i >> 2) + (i & 3)) & 3)];
        end
        if (!last)
        begin
            for (int c = 0; c < 4; c++)
            begin
                x  = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
                a0 = t[4*c];
                t[4*c]   = t[4*c]   ^ x ^ xt(t[4*c]   ^ t[4*c+1]);
                t[4*c+1] = t[4*c+1] ^ x ^ xt(t[4*c+1] ^ t[4*c+2]);
                t[4*c+2] = t[4*c+2] ^ x ^ xt(t[4*c+2] ^ t[4*c+3]);
                t[4*c+3] = t[4*c+3] ^ x ^ xt(t[4*c+3] ^ a0);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            r[127-8*i -: 8] = t[i] ^ k[127-8*i -: 8];
        end
        return r;
    endfunction

    function automatic logic [127:0] dec_round(input logic [127:0] s,
                                               input logic [127:0] k,
                                               input logic         nomix);
        logic [7:0]   a [16];
        logic [7:0]   b [4];
        logic [7:0]   m2 [4];
        logic [7:0]   m4 [4];
        logic [7:0]   m8 [4];
        logic [127:0] r;
        for (int i = 0; i < 16; i++)
        begin
            a[i] = INV_SBOX[s[127-8*((i & 3) + 4 * (((i >> 2) + 4 - (i & 3)) & 3)) -: 8]]
                   ^ k[127-8*i -: 8];
        end
        if (!nomix)
        begin
            for (int c = 0; c < 4; c++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    b[j]  = a[4*c+j];
                    m2[j] = xt(b[j]);
                    m4[j] = xt(m2[j]);
                    m8[j] = xt(m4[j]);
                end
                // 14 = 8^4^2, 11 = 8^2^1, 13 = 8^4^1, 9 = 8^1
                a[4*c]   = (m8[0]^m4[0]^m2[0]) ^ (m8[1]^m2[1]^b[1])
                         ^ (m8[2]^m4[2]^b[2])  ^ (m8[3]^b[3]);
                a[4*c+1] = (m8[0]^b[0])        ^ (m8[1]^m4[1]^m2[1])
                         ^ (m8[2]^m2[2]^b[2])  ^ (m8[3]^m4[3]^b[3]);
                a[4*c+2] = (m8[0]^m4[0]^b[0])  ^ (m8[1]^b[1])
                         ^ (m8[2]^m4[2]^m2[2]) ^ (m8[3]^m2[3]^b[3]);
                a[4*c+3] = (m8[0]^m2[0]^b[0])  ^ (m8[1]^m4[1]^b[1])
                         ^ (m8[2]^b[2])        ^ (m8[3]^m4[3]^m2[3]);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            r[127-8*i -: 8] = a[i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/aes_cbc_pkcs5_stream.sv
// ----------------------------------------------------------------------------
// aes_cbc_pkcs5_stream
// AES-128/192/256 CBC byte stream with PKCS#5/7 padding, one round per cycle.
// ----------------------------------------------------------------------------
//  channel   signals                              role
//  in        in_valid, in_stall, command/data     command word, one per item
//  out       out_valid, out_stall, out_byte...    result word, up to 16 per item
//  cfg       cfg_write, cfg_index, cfg_data       register write, no wait
//
//  Start: key expansion of 4*(Nr+1) words (44, 52 or 60), one word a cycle.
//  Data byte: stored; a full block goes through the round unit, then results go
//  out one word a cycle unless out_stall. Finish: round unit (encrypt) + results.
//  in_stall is high whenever the sequencer is busy; out_stall holds the word.
//  Reset clears control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_cbc_pkcs5_stream
    import aescbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             byte_valid,
    output logic             run_last,
    output logic             message_done,
    output logic [1:0]       status
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_KEY  = 4'b0010,
        S_RUN  = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t       state_reg;
    logic [1:0]   mode_reg;
    logic [1:0]   err_reg;
    logic         dir_reg;
    logic [1:0]   ks_reg;
    logic [63:0]  key_reg [4];
    logic [63:0]  iv_hi_reg;
    logic [63:0]  iv_lo_reg;

    logic [127:0] chain_reg;
    logic [127:0] gather_reg;
    logic [3:0]   gcnt_reg;
    logic [127:0] held_reg;
    logic         held_v_reg;
    logic [3:0]   nr_reg;
    logic [3:0]   nk_reg;

    logic [31:0]  win_reg [8];
    logic [5:0]   wcnt_reg;
    logic [2:0]   kmod_reg;
    logic [7:0]   rcon_reg;
    logic [127:0] rk_reg [15];

    logic [127:0] blk_reg;
    logic [3:0]   rnd_reg;
    logic         first_reg;
    logic         fin_reg;
    logic         pend_reg;

    logic [127:0] oblk_reg;
    logic [4:0]   on_reg;
    logic [3:0]   oidx_reg;
    logic         odone_reg;
    logic         ostat_reg;
    logic [1:0]   ocode_reg;

    logic         in_acc;
    logic         out_acc;
    logic         active;
    logic [127:0] gather_next;
    logic [127:0] padded;
    logic [4:0]   pad5;
    logic [7:0]   pad_b;
    logic         bad_len;
    logic         bad_pad;
    logic [8:0]   psum;
    logic [127:0] rk_sel;
    logic [127:0] step_out;
    logic         run_done;
    logic [31:0]  kw_old;
    logic [31:0]  kw_t;
    logic [31:0]  kw_new;
    logic [5:0]   k_total;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = (state_reg == S_EMIT);
    assign out_acc   = out_valid && !out_stall;
    assign active    = (mode_reg == MODE_ENC) || (mode_reg == MODE_DEC);

    always_comb
    begin
        gather_next = gather_reg;
        pad5 = 5'd16 - {1'b0, gcnt_reg};
        padded = gather_reg;
        for (int i = 0; i < 16; i++)
        begin
            if (4'(i) == gcnt_reg)
            begin
                gather_next[127-8*i -: 8] = data_byte;
            end
            if (4'(i) >= gcnt_reg)
            begin
                padded[127-8*i -: 8] = {3'b000, pad5};
            end
        end
    end

    always_comb
    begin
        pad_b   = held_reg[7:0];
        bad_len = (gcnt_reg != 4'd0) || !held_v_reg;
        bad_pad = !(pad_b inside {[8'd1:8'd16]});
        psum    = 9'd0;
        for (int i = 0; i < 16; i++)
        begin
            psum = 9'(i) + {1'b0, pad_b};
            if ((psum >= 9'd16) && (held_reg[127-8*i -: 8] != pad_b))
            begin
                bad_pad = 1'b1;
            end
        end
    end

    always_comb
    begin
        rk_sel = rk_reg[rnd_reg];
        if (first_reg)
        begin
            step_out = blk_reg ^ rk_sel;
        end
        else if (mode_reg == MODE_DEC)
        begin
            step_out = dec_round(blk_reg, rk_sel, rnd_reg == 4'd0);
        end
        else
        begin
            step_out = enc_round(blk_reg, rk_sel, rnd_reg == nr_reg);
        end
        run_done = !first_reg &&
                   ((mode_reg == MODE_DEC) ? (rnd_reg == 4'd0) : (rnd_reg == nr_reg));
    end

    always_comb
    begin
        case (nk_reg)
            4'd4:    kw_old = win_reg[4];
            4'd6:    kw_old = win_reg[2];
            default: kw_old = win_reg[0];
        endcase
        if (kmod_reg == 3'd0)
        begin
            kw_t = sub_word({win_reg[7][23:0], win_reg[7][31:24]}) ^ {rcon_reg, 24'd0};
        end
        else if ((nk_reg == 4'd8) && (kmod_reg == 3'd4))
        begin
            kw_t = sub_word(win_reg[7]);
        end
        else
        begin
            kw_t = win_reg[7];
        end
        kw_new  = (wcnt_reg < {2'b00, nk_reg}) ? win_reg[0] : (kw_old ^ kw_t);
        k_total = {nr_reg + 4'd1, 2'b00};
    end

    always_comb
    begin
        out_byte = 8'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (4'(i) == oidx_reg)
            begin
                out_byte = oblk_reg[127-8*i -: 8];
            end
        end
        if (ostat_reg)
        begin
            out_byte = 8'd0;
        end
        byte_valid   = !ostat_reg;
        run_last     = ({1'b0, oidx_reg} == (on_reg - 5'd1));
        message_done = run_last && odone_reg;
        status       = ostat_reg ? ocode_reg : ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg    <= 1'b0;
            ks_reg     <= 2'd0;
            key_reg[0] <= 64'd0;
            key_reg[1] <= 64'd0;
            key_reg[2] <= 64'd0;
            key_reg[3] <= 64'd0;
            iv_hi_reg  <= 64'd0;
            iv_lo_reg  <= 64'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DIR:   dir_reg    <= cfg_data[0];
                REG_KSIZE: ks_reg     <= cfg_data[1:0];
                REG_KEY0:  key_reg[0] <= cfg_data;
                REG_KEY1:  key_reg[1] <= cfg_data;
                REG_KEY2:  key_reg[2] <= cfg_data;
                REG_KEY3:  key_reg[3] <= cfg_data;
                REG_IVHI:  iv_hi_reg  <= cfg_data;
                REG_IVLO:  iv_lo_reg  <= cfg_data;
                default:   dir_reg    <= dir_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mode_reg   <= MODE_IDLE;
            err_reg    <= ST_OK;
            chain_reg  <= 128'd0;
            gcnt_reg   <= 4'd0;
            held_v_reg <= 1'b0;
            nr_reg     <= 4'd10;
            nk_reg     <= 4'd4;
            wcnt_reg   <= 6'd0;
            kmod_reg   <= 3'd0;
            rcon_reg   <= 8'd1;
            rnd_reg    <= 4'd0;
            first_reg  <= 1'b0;
            fin_reg    <= 1'b0;
            pend_reg   <= 1'b0;
            on_reg     <= 5'd1;
            oidx_reg   <= 4'd0;
            odone_reg  <= 1'b0;
            ostat_reg  <= 1'b0;
            ocode_reg  <= ST_OK;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        case (command)
                            CMD_START:
                            begin
                                chain_reg  <= {iv_hi_reg, iv_lo_reg};
                                gcnt_reg   <= 4'd0;
                                held_v_reg <= 1'b0;
                                err_reg    <= ST_OK;
                                mode_reg   <= dir_reg ? MODE_DEC : MODE_ENC;
                                case (ks_reg)
                                    2'd0:
                                    begin
                                        nk_reg <= 4'd4;
                                        nr_reg <= 4'd10;
                                    end
                                    2'd1:
                                    begin
                                        nk_reg <= 4'd6;
                                        nr_reg <= 4'd12;
                                    end
                                    default:
                                    begin
                                        nk_reg <= 4'd8;
                                        nr_reg <= 4'd14;
                                    end
                                endcase
                                for (int j = 0; j < 4; j++)
                                begin
                                    win_reg[2*j]   <= key_reg[j][63:32];
                                    win_reg[2*j+1] <= key_reg[j][31:0];
                                end
                                wcnt_reg  <= 6'd0;
                                kmod_reg  <= 3'd0;
                                rcon_reg  <= 8'd1;
                                state_reg <= S_KEY;
                            end
                            CMD_DATA:
                            begin
                                if (active)
                                begin
                                    gather_reg <= gather_next;
                                    if (gcnt_reg == 4'd15)
                                    begin
                                        gcnt_reg  <= 4'd0;
                                        first_reg <= 1'b1;
                                        fin_reg   <= 1'b0;
                                        state_reg <= S_RUN;
                                        if (mode_reg == MODE_ENC)
                                        begin
                                            blk_reg  <= chain_reg ^ gather_next;
                                            rnd_reg  <= 4'd0;
                                            pend_reg <= 1'b0;
                                        end
                                        else
                                        begin
                                            blk_reg   <= gather_next;
                                            rnd_reg   <= nr_reg;
                                            pend_reg  <= held_v_reg;
                                            oblk_reg  <= held_reg;
                                            on_reg    <= 5'd16;
                                            odone_reg <= 1'b0;
                                            ostat_reg <= 1'b0;
                                        end
                                    end
                                    else
                                    begin
                                        gcnt_reg <= gcnt_reg + 4'd1;
                                    end
                                end
                            end
                            CMD_FINISH:
                            begin
                                case (mode_reg)
                                    MODE_IDLE:
                                    begin
                                        on_reg    <= 5'd1;
                                        odone_reg <= 1'b1;
                                        ostat_reg <= 1'b1;
                                        ocode_reg <= ST_LEN;
                                        state_reg <= S_EMIT;
                                    end
                                    MODE_ERR:
                                    begin
                                        on_reg    <= 5'd1;
                                        odone_reg <= 1'b1;
                                        ostat_reg <= 1'b1;
                                        ocode_reg <= err_reg;
                                        state_reg <= S_EMIT;
                                    end
                                    MODE_ENC:
                                    begin
                                        blk_reg   <= chain_reg ^ padded;
                                        rnd_reg   <= 4'd0;
                                        first_reg <= 1'b1;
                                        fin_reg   <= 1'b1;
                                        gcnt_reg  <= 4'd0;
                                        state_reg <= S_RUN;
                                    end
                                    default:
                                    begin
                                        on_reg    <= 5'd1;
                                        odone_reg <= 1'b1;
                                        ostat_reg <= 1'b1;
                                        state_reg <= S_EMIT;
                                        if (bad_len)
                                        begin
                                            mode_reg  <= MODE_ERR;
                                            err_reg   <= ST_LEN;
                                            ocode_reg <= ST_LEN;
                                        end
                                        else if (bad_pad)
                                        begin
                                            mode_reg  <= MODE_ERR;
                                            err_reg   <= ST_PAD;
                                            ocode_reg <= ST_PAD;
                                        end
                                        else
                                        begin
                                            held_v_reg <= 1'b0;
                                            ocode_reg  <= ST_OK;
                                            if (pad_b != 8'd16)
                                            begin
                                                oblk_reg  <= held_reg;
                                                on_reg    <= 5'd16 - pad_b[4:0];
                                                ostat_reg <= 1'b0;
                                            end
                                        end
                                    end
                                endcase
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_KEY:
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        if (wcnt_reg[1:0] == 2'(j))
                        begin
                            rk_reg[wcnt_reg[5:2]][127-32*j -: 32] <= kw_new;
                        end
                    end
                    for (int j = 0; j < 7; j++)
                    begin
                        win_reg[j] <= win_reg[j+1];
                    end
                    win_reg[7] <= kw_new;
                    kmod_reg <= ({1'b0, kmod_reg} == (nk_reg - 4'd1)) ? 3'd0 : kmod_reg + 3'd1;
                    if ((kmod_reg == 3'd0) && (wcnt_reg >= {2'b00, nk_reg}))
                    begin
                        rcon_reg <= xt(rcon_reg);
                    end
                    wcnt_reg <= wcnt_reg + 6'd1;
                    if (wcnt_reg == k_total - 6'd1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_RUN:
                begin
                    blk_reg   <= step_out;
                    first_reg <= 1'b0;
                    rnd_reg   <= (mode_reg == MODE_DEC) ? rnd_reg - 4'd1 : rnd_reg + 4'd1;
                    if (run_done)
                    begin
                        if (mode_reg == MODE_DEC)
                        begin
                            held_reg   <= step_out ^ chain_reg;
                            chain_reg  <= gather_reg;
                            held_v_reg <= 1'b1;
                            state_reg  <= pend_reg ? S_EMIT : S_IDLE;
                        end
                        else
                        begin
                            chain_reg <= step_out;
                            oblk_reg  <= step_out;
                            on_reg    <= 5'd16;
                            odone_reg <= fin_reg;
                            ostat_reg <= 1'b0;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (out_acc)
                    begin
                        if (run_last)
                        begin
                            oidx_reg  <= 4'd0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            oidx_reg <= oidx_reg + 4'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: tb/aes_cbc_pkcs5_stream_tb.sv
// ----------------------------------------------------------------------------
// aes_cbc_pkcs5_stream_tb
// Drives start, data and finish words into the CBC stream block and checks
// each result word against an in-bench AES-CBC/PKCS#7 predictor. Decrypt
// messages are built from ciphertext encrypted by the same predictor.
// ----------------------------------------------------------------------------
module aes_cbc_pkcs5_stream_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import aescbc_pkg::*;

    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [7:0] ob;
        logic       bv;
        logic       last;
        logic       done;
        logic [1:0] st;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  command = CMD_START;
    logic [7:0]  data_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        run_last;
    logic        message_done;
    logic [1:0]  status;

    aes_cbc_pkcs5_stream dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .data_byte(data_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_byte(out_byte), .byte_valid(byte_valid), .run_last(run_last),
        .message_done(message_done), .status(status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    int      errors = 0;
    int      words_sent = 0;
    int      idle_cycles = 0;
    bit      quiet = 1'b0;
    result_t pending_words[$];

    // register copies
    logic         r_dir = 1'b0;
    logic [1:0]   r_ks = '0;
    logic [255:0] r_key = '0;
    logic [127:0] r_iv = '0;

    // predicted block state
    logic [127:0]  chain_m = '0;
    logic [7:0]    gather_m [16];
    int            gcount_m = 0;
    logic [127:0]  held_m = '0;
    logic          held_ok = 1'b0;
    logic [1:0]    mode_m = MODE_IDLE;
    logic [1:0]    err_m = ST_OK;
    logic [1919:0] rk_m = '0;
    int            nr_m = 10;

    logic [7:0] sb [256];
    logic [7:0] isb [256];

    function automatic logic [7:0] dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[0])
                r ^= a;
            a = dbl(a);
            b = b >> 1;
        end
        return r;
    endfunction

    initial
    begin
        logic [7:0] inv;
        logic [7:0] v;
        for (int x = 0; x < 256; x++)
        begin
            inv = '0;
            for (int y = 1; y < 256; y++)
                if (gmul(x[7:0], y[7:0]) == 8'h01)
                    inv = y[7:0];
            v = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sb[x] = v;
            isb[v] = x[7:0];
        end
    end

    function automatic int rounds_for(input logic [1:0] ks);
        return (ks == 2'd0) ? 10 : (ks == 2'd1) ? 12 : 14;
    endfunction

    function automatic logic [1919:0] expand_keys(input logic [255:0] key,
                                                  input logic [1:0] ks);
        logic [7:0]    w [240];
        logic [7:0]    t [4];
        logic [7:0]    rc;
        logic [7:0]    tmp;
        logic [1919:0] r;
        int            nk;
        int            total;
        nk = (ks == 2'd0) ? 4 : (ks == 2'd1) ? 6 : 8;
        total = 4 * (nk + 7);
        for (int i = 0; i < 240; i++)
            w[i] = '0;
        for (int k = 0; k < 4 * nk; k++)
            w[k] = key[255-8*k -: 8];
        rc = 8'h01;
        for (int i = nk; i < total; i++)
        begin
            for (int k = 0; k < 4; k++)
                t[k] = w[4*(i-1)+k];
            if (i % nk == 0)
            begin
                tmp = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = tmp;
                for (int k = 0; k < 4; k++)
                    t[k] = sb[t[k]];
                t[0] ^= rc;
                rc = dbl(rc);
            end
            else if (nk > 6 && i % nk == 4)
            begin
                for (int k = 0; k < 4; k++)
                    t[k] = sb[t[k]];
            end
            for (int k = 0; k < 4; k++)
                w[4*i+k] = w[4*(i-nk)+k] ^ t[k];
        end
        for (int i = 0; i < 240; i++)
            r[1919-8*i -: 8] = w[i];
        return r;
    endfunction

    function automatic logic [127:0] encipher(input logic [127:0] blk,
                                              input logic [1919:0] rk, input int nr);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] x;
        logic [7:0] a0;
        logic [127:0] r;
        for (int i = 0; i < 16; i++)
            s[i] = blk[127-8*i -: 8] ^ rk[1919-8*i -: 8];
        for (int rn = 1; rn <= nr; rn++)
        begin
            for (int i = 0; i < 16; i++)
                s[i] = sb[s[i]];
            for (int i = 0; i < 16; i++)
                t[i] = s[(i & 3) + 4 * (((i >> 2) + (i & 3)) & 3)];
            if (rn != nr)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    x  = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
                    a0 = t[4*c];
                    t[4*c]   ^= x ^ dbl(t[4*c] ^ t[4*c+1]);
                    t[4*c+1] ^= x ^ dbl(t[4*c+1] ^ t[4*c+2]);
                    t[4*c+2] ^= x ^ dbl(t[4*c+2] ^ t[4*c+3]);
                    t[4*c+3] ^= x ^ dbl(t[4*c+3] ^ a0);
                end
            end
            for (int i = 0; i < 16; i++)
                s[i] = t[i] ^ rk[1919-8*(16*rn+i) -: 8];
        end
        for (int i = 0; i < 16; i++)
            r[127-8*i -: 8] = s[i];
        return r;
    endfunction

    function automatic logic [127:0] decipher(input logic [127:0] blk,
                                              input logic [1919:0] rk, input int nr);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] b0, b1, b2, b3;
        logic [127:0] r;
        for (int i = 0; i < 16; i++)
            s[i] = blk[127-8*i -: 8] ^ rk[1919-8*(16*nr+i) -: 8];
        for (int rn = nr - 1; rn >= 0; rn--)
        begin
            for (int i = 0; i < 16; i++)
                t[i] = s[(i & 3) + 4 * (((i >> 2) + 4 - (i & 3)) & 3)];
            for (int i = 0; i < 16; i++)
                s[i] = isb[t[i]] ^ rk[1919-8*(16*rn+i) -: 8];
            if (rn != 0)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    b0 = s[4*c]; b1 = s[4*c+1]; b2 = s[4*c+2]; b3 = s[4*c+3];
                    s[4*c]   = gmul(b0, 14) ^ gmul(b1, 11) ^ gmul(b2, 13) ^ gmul(b3, 9);
                    s[4*c+1] = gmul(b0, 9) ^ gmul(b1, 14) ^ gmul(b2, 11) ^ gmul(b3, 13);
                    s[4*c+2] = gmul(b0, 13) ^ gmul(b1, 9) ^ gmul(b2, 14) ^ gmul(b3, 11);
                    s[4*c+3] = gmul(b0, 11) ^ gmul(b1, 13) ^ gmul(b2, 9) ^ gmul(b3, 14);
                end
            end
        end
        for (int i = 0; i < 16; i++)
            r[127-8*i -: 8] = s[i];
        return r;
    endfunction

    function automatic void push_word(input logic [7:0] b, input logic bv, input logic last,
                                      input logic done, input logic [1:0] st);
        result_t w;
        w.ob = b; w.bv = bv; w.last = last; w.done = done; w.st = st;
        pending_words.push_back(w);
    endfunction

    function automatic void push_block(input logic [127:0] blk, input int n, input logic done);
        for (int i = 0; i < n; i++)
            push_word(blk[127-8*i -: 8], 1'b1, i == n - 1, (i == n - 1) ? done : 1'b0, ST_OK);
    endfunction

    function automatic void abort_message(input logic [1:0] code);
        mode_m = MODE_ERR;
        err_m = code;
        push_word(8'h00, 1'b0, 1'b1, 1'b1, code);
    endfunction

    function automatic logic [127:0] gathered();
        logic [127:0] r;
        for (int i = 0; i < 16; i++)
            r[127-8*i -: 8] = gather_m[i];
        return r;
    endfunction

    function automatic void cbc_predict(input logic [1:0] cmd, input logic [7:0] b);
        logic [127:0] blk;
        int           pad;
        logic         bad;
        case (cmd)
            CMD_START:
            begin
                chain_m = r_iv;
                gcount_m = 0;
                held_ok = 1'b0;
                err_m = ST_OK;
                mode_m = r_dir ? MODE_DEC : MODE_ENC;
                rk_m = expand_keys(r_key, r_ks);
                nr_m = rounds_for(r_ks);
            end
            CMD_DATA:
            begin
                if (mode_m == MODE_ENC || mode_m == MODE_DEC)
                begin
                    gather_m[gcount_m] = b;
                    gcount_m++;
                    if (gcount_m == 16)
                    begin
                        gcount_m = 0;
                        blk = gathered();
                        if (mode_m == MODE_ENC)
                        begin
                            chain_m = encipher(chain_m ^ blk, rk_m, nr_m);
                            push_block(chain_m, 16, 1'b0);
                        end
                        else
                        begin
                            if (held_ok)
                                push_block(held_m, 16, 1'b0);
                            held_m = decipher(blk, rk_m, nr_m) ^ chain_m;
                            chain_m = blk;
                            held_ok = 1'b1;
                        end
                    end
                end
            end
            CMD_FINISH:
            begin
                if (mode_m == MODE_IDLE)
                    push_word(8'h00, 1'b0, 1'b1, 1'b1, ST_LEN);
                else if (mode_m == MODE_ERR)
                    push_word(8'h00, 1'b0, 1'b1, 1'b1, err_m);
                else if (mode_m == MODE_ENC)
                begin
                    pad = 16 - gcount_m;
                    for (int i = gcount_m; i < 16; i++)
                        gather_m[i] = pad[7:0];
                    chain_m = encipher(chain_m ^ gathered(), rk_m, nr_m);
                    gcount_m = 0;
                    push_block(chain_m, 16, 1'b1);
                end
                else
                begin
                    pad = held_m[7:0];
                    if (gcount_m != 0 || !held_ok)
                        abort_message(ST_LEN);
                    else if (pad < 1 || pad > 16)
                        abort_message(ST_PAD);
                    else
                    begin
                        bad = 1'b0;
                        for (int i = 16 - pad; i < 16; i++)
                            if (held_m[127-8*i -: 8] != pad[7:0])
                                bad = 1'b1;
                        if (bad)
                            abort_message(ST_PAD);
                        else
                        begin
                            held_ok = 1'b0;
                            if (pad == 16)
                                push_word(8'h00, 1'b0, 1'b1, 1'b1, ST_OK);
                            else
                                push_block(held_m, 16 - pad, 1'b1);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // result checker and output stall
    always @(posedge clk)
    begin
        result_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected result word out_byte %0h status %0d", out_byte, status);
                errors++;
            end
            else
            begin
                w = pending_words.pop_front();
                if (out_byte !== w.ob)
                begin
                    $error("out_byte exp %0h got %0h", w.ob, out_byte);
                    errors++;
                end
                if (byte_valid !== w.bv)
                begin
                    $error("byte_valid exp %0b got %0b", w.bv, byte_valid);
                    errors++;
                end
                if (run_last !== w.last)
                begin
                    $error("run_last exp %0b got %0b", w.last, run_last);
                    errors++;
                end
                if (message_done !== w.done)
                begin
                    $error("message_done exp %0b got %0b", w.done, message_done);
                    errors++;
                end
                if (status !== w.st)
                begin
                    $error("status exp %0d got %0d", w.st, status);
                    errors++;
                end
            end
        end
        out_stall <= !quiet && ($urandom_range(99) < 36);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] cmd, input logic [7:0] b);
        if (!quiet && $urandom_range(99) < 36)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        cbc_predict(cmd, b);
        words_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_DIR:   r_dir = val[0];
            REG_KSIZE: r_ks = val[1:0];
            REG_KEY0:  r_key[255:192] = val;
            REG_KEY1:  r_key[191:128] = val;
            REG_KEY2:  r_key[127:64] = val;
            REG_KEY3:  r_key[63:0] = val;
            REG_IVHI:  r_iv[127:64] = val;
            default:   r_iv[63:0] = val;
        endcase
    endtask

    task automatic configure(input logic dir, input logic [1:0] ks,
                             input logic [255:0] key, input logic [127:0] iv);
        wait_idle();
        write_reg(REG_DIR, {63'd0, dir});
        write_reg(REG_KSIZE, {62'd0, ks});
        write_reg(REG_KEY0, key[255:192]);
        write_reg(REG_KEY1, key[191:128]);
        write_reg(REG_KEY2, key[127:64]);
        write_reg(REG_KEY3, key[63:0]);
        write_reg(REG_IVHI, iv[127:64]);
        write_reg(REG_IVLO, iv[63:0]);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_config(input logic dir);
        logic [1:0] ks;
        ks = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
        configure(dir, ks, {rand64(), rand64(), rand64(), rand64()}, {rand64(), rand64()});
    endtask

    task automatic send_plain_msg(input int len);
        send_word(CMD_START, 8'($urandom));
        for (int i = 0; i < len; i++)
            send_word(CMD_DATA, 8'($urandom));
        send_word(CMD_FINISH, 8'($urandom));
    endtask

    // fault: 0 well formed, 1 wrong length, 2 damaged padding
    task automatic send_cipher_msg(input int len, input int fault);
        logic [1919:0] rk;
        logic [127:0]  chn;
        logic [127:0]  blk;
        logic [7:0]    pt[$];
        logic [7:0]    ct[$];
        int            nr;
        int            total;
        int            pad;
        rk = expand_keys(r_key, r_ks);
        nr = rounds_for(r_ks);
        chn = r_iv;
        total = (len / 16 + 1) * 16;
        pad = total - len;
        for (int i = 0; i < len; i++)
            pt.push_back(8'($urandom));
        for (int i = 0; i < pad; i++)
            pt.push_back(pad[7:0]);
        if (fault == 2)
        begin
            if ($urandom_range(1))
                pt[total-1] = 8'($urandom);
            else
                pt[total-2] ^= 8'h01;
        end
        for (int n = 0; n < total / 16; n++)
        begin
            for (int i = 0; i < 16; i++)
                blk[127-8*i -: 8] = pt[16*n+i];
            chn = encipher(blk ^ chn, rk, nr);
            for (int i = 0; i < 16; i++)
                ct.push_back(chn[127-8*i -: 8]);
        end
        if (fault == 1)
        begin
            if ($urandom_range(1))
                void'(ct.pop_back());
            else
                ct.push_back(8'($urandom));
        end
        send_word(CMD_START, 8'($urandom));
        foreach (ct[i])
            send_word(CMD_DATA, ct[i]);
        send_word(CMD_FINISH, 8'($urandom));
    endtask

    task automatic test_directed();
        send_word(CMD_FINISH, 8'h00);
        send_word(CMD_DATA, 8'hff);
        send_word(CMD_NOP, 8'h00);
        send_word(CMD_START, 8'h00);
        send_word(CMD_FINISH, 8'h00);
        send_word(CMD_FINISH, 8'hff);
        configure(1'b1, 2'd0, '0, '0);
        send_word(CMD_START, 8'h00);
        send_word(CMD_FINISH, 8'h00);
        send_word(CMD_FINISH, 8'h00);
        send_word(CMD_DATA, 8'h55);
        send_word(CMD_START, 8'h00);
        send_word(CMD_DATA, 8'haa);
        send_word(CMD_FINISH, 8'h00);
        configure(1'b0, 2'd2, '1, '1);
        send_word(CMD_START, 8'hff);
        send_word(CMD_DATA, 8'h00);
        send_word(CMD_DATA, 8'hff);
        send_word(CMD_FINISH, 8'h00);
        configure(1'b0, 2'd3, '1, '0);
        send_word(CMD_START, 8'h00);
        send_word(CMD_FINISH, 8'h00);
    endtask

    task automatic test_encrypt();
        int stop;
        stop = words_sent + 90;
        quiet = 1'b1;
        while (words_sent < stop)
        begin
            random_config(1'b0);
            repeat (3)
            begin
                send_plain_msg(($urandom_range(9) == 0) ? $urandom_range(33, 48)
                                                        : $urandom_range(0, 20));
                if ($urandom_range(3) == 0)
                begin
                    send_word(CMD_DATA, 8'($urandom));
                    send_word(CMD_FINISH, 8'($urandom));
                end
            end
            quiet = 1'b0;
        end
    endtask

    task automatic test_decrypt();
        int stop;
        int r;
        stop = words_sent + 110;
        while (words_sent < stop)
        begin
            random_config(1'b1);
            repeat (3)
            begin
                r = $urandom_range(9);
                send_cipher_msg(($urandom_range(7) == 0) ? $urandom_range(33, 40)
                                                         : $urandom_range(0, 20),
                                (r < 7) ? 0 : (r < 8) ? 1 : 2);
            end
        end
    endtask

    task automatic test_mixed();
        int stop;
        int r;
        stop = words_sent + 40;
        while (words_sent < stop)
        begin
            random_config(1'($urandom_range(1)));
            repeat (20)
            begin
                r = $urandom_range(9);
                send_word((r < 2) ? CMD_START : (r < 7) ? CMD_DATA :
                          (r < 9) ? CMD_FINISH : CMD_NOP, 8'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_encrypt();
        test_decrypt();
        test_mixed();
        wait_idle();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/core/aescbc_pkg.sv
rtl/core/aes_cbc_pkcs5_stream.sv
tb/aes_cbc_pkcs5_stream_tb.sv
